FILE: sv/lpf_pkg.sv
// shared constants for the largest prime factor block
`default_nettype none
package lpf_pkg;
   localparam int VALUE_WIDTH = 32;
   localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);

   localparam logic [VALUE_WIDTH-1:0] VAL_ZERO  = VALUE_WIDTH'(0);
   localparam logic [VALUE_WIDTH-1:0] VAL_TWO   = VALUE_WIDTH'(2);
   localparam logic [VALUE_WIDTH-1:0] VAL_THREE = VALUE_WIDTH'(3);

   // handshake between the sequencer and the divider
   typedef struct packed {
      logic start;
   } div_req_type;

   typedef struct packed {
      logic done;
   } div_rsp_type;
endpackage
`default_nettype wire

FILE: sv/lpf_divider.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module lpf_divider
   import lpf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire div_req_type            div_req,
   input  wire logic [VALUE_WIDTH-1:0] dividend,
   input  wire logic [VALUE_WIDTH-1:0] divisor,
   output div_rsp_type                 div_rsp,
   output logic [VALUE_WIDTH-1:0]      quotient,
   output logic [VALUE_WIDTH-1:0]      remainder
);
   logic [VALUE_WIDTH-1:0] rem_ff, rem_in;
   logic [VALUE_WIDTH-1:0] quo_ff, quo_in;
   logic [VALUE_WIDTH-1:0] dsr_ff, dsr_in;
   logic [CNT_WIDTH-1:0]   cnt_ff, cnt_in;
   logic                   done_ff, done_in;
   logic [VALUE_WIDTH:0]   shifted;
   logic [VALUE_WIDTH:0]   trial;

   always_comb begin
      shifted = {rem_ff, quo_ff[VALUE_WIDTH-1]};
      trial   = shifted - {1'b0, dsr_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dsr_in  = dsr_ff;
      cnt_in  = cnt_ff;
      done_in = 1'b0;
      if (div_req.start) begin
         rem_in = VAL_ZERO;
         quo_in = dividend;
         dsr_in = divisor;
         cnt_in = CNT_WIDTH'(VALUE_WIDTH);
      end else if (cnt_ff != '0) begin
         if (!trial[VALUE_WIDTH]) begin
            rem_in = trial[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[VALUE_WIDTH-1:0];
            quo_in = {quo_ff[VALUE_WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - CNT_WIDTH'(1);
         done_in = (cnt_ff == CNT_WIDTH'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done = done_ff;
   assign quotient     = quo_ff;
   assign remainder    = rem_ff;
endmodule
`default_nettype wire

FILE: sv/largest_prime_factor.sv
// largest prime factor by trial division over a shared divider
//
//   channel  ports                          transfer when
//   request  start, busy, req_value         start high and busy low
//   result   rsp_valid, rsp_largest_factor  rsp_valid high, one cycle
//
// an item first shifts out factors of two, one bit per cycle, then runs one
// division per odd trial divisor and per factor divided out, each in the
// shared divider; the worst case at 32 bits is about 32768 divisions
// inputs 0 and 1 answer straight from idle; busy stays high until the result
// synchronous reset clears the sequencer and divider control; no stall on results
`default_nettype none
module largest_prime_factor
   import lpf_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   output logic                        busy,
   input  wire logic [VALUE_WIDTH-1:0] req_value,
   output logic                        rsp_valid,
   output logic [VALUE_WIDTH-1:0]      rsp_largest_factor
);
   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_STRIP    = 5'b00010,
      ST_DIV_GO   = 5'b00100,
      ST_DIV_WAIT = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   state_type              state_ff, state_in;
   logic [VALUE_WIDTH-1:0] n_ff, n_in;
   logic [VALUE_WIDTH-1:0] d_ff, d_in;
   logic [VALUE_WIDTH-1:0] best_ff, best_in;
   logic                   head_ff, head_in;
   logic                   valid_ff, valid_in;
   logic [VALUE_WIDTH-1:0] result_ff, result_in;
   div_req_type            div_req;
   div_rsp_type            div_rsp;
   logic [VALUE_WIDTH-1:0] quotient;
   logic [VALUE_WIDTH-1:0] remainder;

   lpf_divider u_divider (
      .clock     (clock),
      .reset     (reset),
      .div_req   (div_req),
      .dividend  (n_ff),
      .divisor   (d_ff),
      .div_rsp   (div_rsp),
      .quotient  (quotient),
      .remainder (remainder)
   );

   always_comb begin
      state_in      = state_ff;
      n_in          = n_ff;
      d_in          = d_ff;
      best_in       = best_ff;
      head_in       = head_ff;
      valid_in      = 1'b0;
      result_in     = result_ff;
      div_req.start = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               n_in    = req_value;
               best_in = VAL_ZERO;
               if (req_value < VAL_TWO) begin
                  valid_in  = 1'b1;
                  result_in = VAL_ZERO;
               end else begin
                  state_in = ST_STRIP;
               end
            end
         end
         ST_STRIP: begin
            if (!n_ff[0]) begin
               n_in    = n_ff >> 1;
               best_in = VAL_TWO;
            end else begin
               d_in     = VAL_THREE;
               head_in  = 1'b1;
               state_in = ST_DIV_GO;
            end
         end
         ST_DIV_GO: begin
            div_req.start = 1'b1;
            state_in      = ST_DIV_WAIT;
         end
         ST_DIV_WAIT: begin
            if (div_rsp.done) begin
               // bound test d <= n/d only when a new divisor is tried
               if (head_ff && (d_ff > quotient)) begin
                  state_in = ST_FINISH;
               end else if (remainder == VAL_ZERO) begin
                  best_in  = d_ff;
                  n_in     = quotient;
                  head_in  = 1'b0;
                  state_in = ST_DIV_GO;
               end else begin
                  d_in     = d_ff + VAL_TWO;
                  head_in  = 1'b1;
                  state_in = ST_DIV_GO;
               end
            end
         end
         ST_FINISH: begin
            valid_in  = 1'b1;
            result_in = (n_ff > VAL_TWO) ? n_ff : best_ff;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
      n_ff      <= n_in;
      d_ff      <= d_in;
      best_ff   <= best_in;
      head_ff   <= head_in;
      result_ff <= result_in;
   end

   assign busy               = (state_ff != ST_IDLE);
   assign rsp_valid          = valid_ff;
   assign rsp_largest_factor = result_ff;
endmodule
`default_nettype wire
